// ----- design/eased_tween_table_unit_assert.svh -----
// Assertion macros for the eased tween table unit.
// Used by files that take it by include; needs clk and arst_n in scope.
`ifndef EASED_TWEEN_TABLE_UNIT_ASSERT_SVH
`define EASED_TWEEN_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define ETW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ETW_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);
`else
`define ETW_ASSERT(label, prop, msg)
`define ETW_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ----- design/etw_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the eased tween table unit.
// No dependencies.
package etw_pkg;
	localparam int MAX_ENTRIES_DEF = 32;
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [17:0] BACK_OVERSHOOT_RST = 18'd111514;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_GET   = 2'd2;

	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_ABSENT   = 2'd3;

	localparam logic [1:0] EASE_LINEAR = 2'd0;
	localparam logic [1:0] EASE_BACK   = 2'd1;
	localparam logic [1:0] EASE_CUBIC  = 2'd2;
	localparam logic [1:0] EASE_QUINT  = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [63:0]        key;
		logic signed [31:0] amount;
		logic [31:0]        duration;
		logic [31:0]        elapsed;
		logic [1:0]         ease;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         status;
		logic [5:0]         removed;
	} out_item_t;

	typedef struct packed {
		logic [63:0] key;
		logic [16:0] prog;
		logic [31:0] dur;
		logic [31:0] start;
		logic [31:0] last;
		logic [1:0]  ease;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_MISS,
		S_GE1, S_GE2, S_GE3, S_GE4, S_GE5, S_GE6,
		S_TICK_RD, S_TICK_WAIT, S_TICK_DIV, S_TICK_CP, S_RESP
	} state_t;
endpackage

// ----- design/etw_div.sv -----
`timescale 1ns / 1ps
// Tick ratio divider: (elapsed << 16) / duration, capped at 1.0, one bit a cycle.
// Depends on etw_pkg.
module etw_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [16:0] quot
);
	logic        busy_q;
	logic [3:0]  cnt_q;
	logic [32:0] r_q;
	logic [31:0] den_q;
	logic [15:0] qb_q;
	logic        done_q;
	logic [16:0] quot_q;
	logic [32:0] r2;

	assign r2 = {r_q[31:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				if (num >= den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q && cnt_q == 4'd15) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			cnt_q  <= '0;
			r_q    <= {1'b0, num};
			den_q  <= den;
			qb_q   <= '0;
			quot_q <= etw_pkg::ONE_Q16;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (r2 >= {1'b0, den_q}) begin
				r_q  <= r2 - {1'b0, den_q};
				qb_q <= {qb_q[14:0], 1'b1};
				quot_q <= {1'b0, qb_q[14:0], 1'b1};
			end else begin
				r_q  <= r2;
				qb_q <= {qb_q[14:0], 1'b0};
				quot_q <= {1'b0, qb_q[14:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

// ----- design/eased_tween_table_unit.sv -----
`timescale 1ns / 1ps
// Eased tween table unit: keyed tween store with start, get and tick commands.
// Depends on etw_pkg, etw_div and eased_tween_table_unit_assert.svh.
//
// One item is handled at a time. Start and get search the table entry by entry
// (memory read then compare), and a found get then runs through the easing
// arithmetic states. A tick walks the live entries from the last down, reading
// each and running the 16-step duration divider on it (skipped when the ratio
// caps at 1.0), plus a copy of the last live entry into each removed slot that
// is not itself the last.
// The entries live in one single-port-read, single-port-write memory.
module eased_tween_table_unit #(
	parameter int MAX_ENTRIES = etw_pkg::MAX_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  etw_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output etw_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic [17:0]         cfg_wdata
);
	`include "eased_tween_table_unit_assert.svh"

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	etw_pkg::entry_t mem [MAX_ENTRIES];
	etw_pkg::entry_t rd_q;
	etw_pkg::state_t state_q, state_d;
	etw_pkg::in_item_t in_q;
	etw_pkg::out_item_t res_q, out_q;

	logic [17:0]        bo_q;
	logic [CW-1:0]      n_q, rem_q;
	logic [AW-1:0]      idx_q;
	logic               out_valid_q;
	logic [16:0]        q_q, q2_q, q3_q, q5_q;
	logic [18:0]        sq2_q;
	logic [19:0]        sq3_q;
	logic signed [21:0] e_q;
	logic signed [54:0] prod_q;

	logic               mem_we, rd_en;
	logic [AW-1:0]      mem_waddr, rd_addr;
	etw_pkg::entry_t    mem_wdata;
	logic               div_go, div_done;
	logic [16:0]        div_quot;
	logic               match, search_end, is_last, remove;
	logic [17:0]        sum_w;
	logic signed [32:0] diff_w;
	logic signed [38:0] sh_w;
	logic signed [39:0] v_w;
	logic signed [31:0] st_w, val_w;
	logic [33:0]        pq2, pq3, pq5;
	logic [34:0]        psq2;
	logic [35:0]        psq3;
	logic [18:0]        s1_w;
	logic               out_free;

	assign match      = rd_q.key == in_q.key;
	assign search_end = (CW'(idx_q) + CW'(1)) == n_q;
	assign is_last    = CW'(idx_q) == (n_q - CW'(1));
	assign sum_w      = {1'b0, rd_q.prog} + {1'b0, div_quot};
	assign remove     = sum_w >= {1'b0, etw_pkg::ONE_Q16};
	assign out_free   = !out_valid_q || !out_stall;
	assign div_go     = state_q == etw_pkg::S_TICK_WAIT;

	assign st_w   = $signed(rd_q.start);
	assign diff_w = 33'(in_q.amount) - 33'(st_w);
	assign sh_w   = prod_q[54:16];
	assign v_w    = 40'(st_w) + 40'(sh_w);
	assign s1_w   = {1'b0, bo_q} + 19'(etw_pkg::ONE_Q16);
	assign pq2    = q_q * q_q;
	assign pq3    = q2_q * q_q;
	assign pq5    = q3_q * q2_q;
	assign psq2   = bo_q * q2_q;
	assign psq3   = s1_w * q3_q;

	always_comb begin
		if (v_w > 40'sd2147483647) begin
			val_w = 32'sh7fffffff;
		end else if (v_w < -40'sd2147483648) begin
			val_w = 32'sh80000000;
		end else begin
			val_w = v_w[31:0];
		end
	end

	etw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (in_q.elapsed),
		.den    (rd_q.dur),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= etw_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rd_q;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		case (state_q)
			etw_pkg::S_IDLE: begin
				if (in_valid) begin
					if (in_data.cmd == etw_pkg::CMD_START || in_data.cmd == etw_pkg::CMD_GET) begin
						state_d = (n_q == '0) ? etw_pkg::S_MISS : etw_pkg::S_SRCH_RD;
					end else if (in_data.cmd == etw_pkg::CMD_TICK && n_q != '0) begin
						state_d = etw_pkg::S_TICK_RD;
					end else begin
						state_d = etw_pkg::S_RESP;
					end
				end
			end
			etw_pkg::S_SRCH_RD: begin
				rd_en   = 1'b1;
				state_d = etw_pkg::S_SRCH_CMP;
			end
			etw_pkg::S_SRCH_CMP: begin
				if (match) begin
					if (in_q.cmd == etw_pkg::CMD_GET) begin
						state_d = etw_pkg::S_GE1;
					end else begin
						mem_we          = 1'b1;
						mem_wdata.prog  = '0;
						mem_wdata.dur   = in_q.duration;
						mem_wdata.start = rd_q.last;
						mem_wdata.ease  = in_q.ease;
						state_d         = etw_pkg::S_RESP;
					end
				end else if (search_end) begin
					state_d = etw_pkg::S_MISS;
				end else begin
					state_d = etw_pkg::S_SRCH_RD;
				end
			end
			etw_pkg::S_MISS: begin
				mem_waddr       = AW'(n_q);
				mem_wdata.key   = in_q.key;
				mem_wdata.prog  = '0;
				mem_wdata.dur   = in_q.duration;
				mem_wdata.start = in_q.amount;
				mem_wdata.last  = in_q.amount;
				mem_wdata.ease  = in_q.ease;
				mem_we = (in_q.cmd == etw_pkg::CMD_START) && (n_q < CW'(MAX_ENTRIES));
				state_d = etw_pkg::S_RESP;
			end
			etw_pkg::S_GE1: state_d = etw_pkg::S_GE2;
			etw_pkg::S_GE2: state_d = etw_pkg::S_GE3;
			etw_pkg::S_GE3: state_d = etw_pkg::S_GE4;
			etw_pkg::S_GE4: state_d = etw_pkg::S_GE5;
			etw_pkg::S_GE5: state_d = etw_pkg::S_GE6;
			etw_pkg::S_GE6: begin
				mem_we         = 1'b1;
				mem_wdata.last = val_w;
				state_d        = etw_pkg::S_RESP;
			end
			etw_pkg::S_TICK_RD: begin
				rd_en   = 1'b1;
				state_d = etw_pkg::S_TICK_WAIT;
			end
			etw_pkg::S_TICK_WAIT: state_d = etw_pkg::S_TICK_DIV;
			etw_pkg::S_TICK_DIV: begin
				if (div_done) begin
					if (remove && !is_last) begin
						rd_en   = 1'b1;
						rd_addr = AW'(n_q - CW'(1));
						state_d = etw_pkg::S_TICK_CP;
					end else begin
						mem_we         = !remove;
						mem_wdata.prog = sum_w[16:0];
						state_d = (idx_q == '0) ? etw_pkg::S_RESP : etw_pkg::S_TICK_RD;
					end
				end
			end
			etw_pkg::S_TICK_CP: begin
				mem_we  = 1'b1;
				state_d = (idx_q == '0) ? etw_pkg::S_RESP : etw_pkg::S_TICK_RD;
			end
			etw_pkg::S_RESP: begin
				if (out_free) begin
					state_d = etw_pkg::S_IDLE;
				end
			end
			default: state_d = etw_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bo_q        <= etw_pkg::BACK_OVERSHOOT_RST;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				bo_q <= cfg_wdata;
			end
			if (state_q == etw_pkg::S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == etw_pkg::S_MISS && mem_we) begin
				n_q <= n_q + CW'(1);
			end else if (state_q == etw_pkg::S_TICK_DIV && div_done && remove) begin
				n_q <= n_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			etw_pkg::S_IDLE: begin
				in_q  <= in_data;
				res_q <= '0;
				rem_q <= '0;
				idx_q <= (in_data.cmd == etw_pkg::CMD_TICK) ? AW'(n_q - CW'(1)) : '0;
			end
			etw_pkg::S_SRCH_CMP: begin
				if (match) begin
					q_q <= (rd_q.prog >= etw_pkg::ONE_Q16) ? '0 : etw_pkg::ONE_Q16 - rd_q.prog;
				end else begin
					idx_q <= idx_q + AW'(1);
				end
			end
			etw_pkg::S_MISS: begin
				if (in_q.cmd == etw_pkg::CMD_GET) begin
					res_q.value  <= in_q.amount;
					res_q.status <= etw_pkg::ST_ABSENT;
				end else if (mem_we) begin
					res_q.status <= etw_pkg::ST_INSERTED;
				end else begin
					res_q.status <= etw_pkg::ST_FULL;
				end
			end
			etw_pkg::S_GE1: q2_q <= pq2[32:16];
			etw_pkg::S_GE2: begin
				q3_q  <= pq3[32:16];
				sq2_q <= psq2[34:16];
			end
			etw_pkg::S_GE3: begin
				q5_q  <= pq5[32:16];
				sq3_q <= psq3[35:16];
			end
			etw_pkg::S_GE4: begin
				case (rd_q.ease)
					etw_pkg::EASE_BACK:
						e_q <= 22'(etw_pkg::ONE_Q16) + 22'(sq2_q) - 22'(sq3_q);
					etw_pkg::EASE_CUBIC: e_q <= 22'(etw_pkg::ONE_Q16) - 22'(q3_q);
					etw_pkg::EASE_QUINT: e_q <= 22'(etw_pkg::ONE_Q16) - 22'(q5_q);
					default: e_q <= 22'(rd_q.prog);
				endcase
			end
			etw_pkg::S_GE5: prod_q <= diff_w * e_q;
			etw_pkg::S_GE6: res_q.value <= val_w;
			etw_pkg::S_TICK_DIV: begin
				if (div_done) begin
					if (remove) begin
						rem_q <= rem_q + CW'(1);
					end
					if (!(remove && !is_last) && idx_q != '0) begin
						idx_q <= idx_q - AW'(1);
					end
				end
			end
			etw_pkg::S_TICK_CP: begin
				if (idx_q != '0) begin
					idx_q <= idx_q - AW'(1);
				end
			end
			etw_pkg::S_RESP: begin
				if (out_free) begin
					out_q <= {res_q.value, res_q.status, 6'(rem_q)};
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = state_q != etw_pkg::S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ETW_ASSERT(a_count_bound, n_q <= CW'(MAX_ENTRIES), "live count beyond table size")
	`ETW_ASSERT(a_waddr_bound, !mem_we || (CW'(mem_waddr) < CW'(MAX_ENTRIES)), "write beyond table")
	`ETW_ASSERT_NEXT(a_count_step, 1'b1, ({1'b0, n_q} <= ({1'b0, $past(n_q)} + 1'b1)), "live count jumped")
	`ETW_ASSERT_NEXT(a_busy_stall, state_q != etw_pkg::S_IDLE && state_q != etw_pkg::S_RESP, in_stall, "item taken while busy")
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the eased tween table unit.
// Depends on etw_pkg and the unit; predicts every result from its own model.
module tb_top;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	etw_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	etw_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [17:0] cfg_wdata = '0;

	eased_tween_table_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	logic [17:0] overshoot;
	etw_pkg::entry_t tweens [etw_pkg::MAX_ENTRIES_DEF];
	int unsigned live;
	etw_pkg::out_item_t expected_q[$];
	int unsigned errors = 0;
	longint unsigned cycles = 0;
	logic [63:0] keys_used[$];

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3000000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic longint eased(logic [16:0] p, logic [1:0] kind);
		longint unsigned q, q2, q3, q5, s;
		q = (p >= 17'h10000) ? 0 : 64'h10000 - p;
		q2 = (q * q) >> 16;
		q3 = (q2 * q) >> 16;
		q5 = (q3 * q2) >> 16;
		s = overshoot;
		case (kind)
			etw_pkg::EASE_BACK: return 65536 + longint'((s * q2) >> 16)
				- longint'(((s + 65536) * q3) >> 16);
			etw_pkg::EASE_CUBIC: return 65536 - longint'(q3);
			etw_pkg::EASE_QUINT: return 65536 - longint'(q5);
			default: return longint'(p);
		endcase
	endfunction

	function automatic int lookup(logic [63:0] k);
		for (int i = 0; i < live; i++)
			if (tweens[i].key == k) return i;
		return -1;
	endfunction

	function automatic etw_pkg::out_item_t predict_table(etw_pkg::in_item_t it);
		etw_pkg::out_item_t r;
		int idx;
		int unsigned n;
		longint unsigned ratio, sum;
		longint e, st, tgt, prod, v;
		r = '0;
		case (it.cmd)
			etw_pkg::CMD_TICK: begin
				n = live;
				for (int i = int'(live) - 1; i >= 0; i--) begin
					if (tweens[i].dur == 0) ratio = 65536;
					else ratio = ({32'd0, it.elapsed} << 16) / tweens[i].dur;
					if (ratio > 65536) ratio = 65536;
					sum = tweens[i].prog + ratio;
					if (sum >= 65536) begin
						tweens[i] = tweens[n - 1];
						n--;
						r.removed++;
					end else begin
						tweens[i].prog = sum[16:0];
					end
				end
				live = n;
				r.status = etw_pkg::ST_FOUND;
			end
			etw_pkg::CMD_START: begin
				idx = lookup(it.key);
				if (idx >= 0) begin
					tweens[idx].start = tweens[idx].last;
					tweens[idx].dur = it.duration;
					tweens[idx].prog = '0;
					tweens[idx].ease = it.ease;
					r.status = etw_pkg::ST_FOUND;
				end else if (live < etw_pkg::MAX_ENTRIES_DEF) begin
					tweens[live] = '{it.key, 17'd0, it.duration, it.amount, it.amount, it.ease};
					live++;
					r.status = etw_pkg::ST_INSERTED;
				end else begin
					r.status = etw_pkg::ST_FULL;
				end
			end
			etw_pkg::CMD_GET: begin
				idx = lookup(it.key);
				if (idx >= 0) begin
					e = eased(tweens[idx].prog, tweens[idx].ease);
					st = longint'(signed'(tweens[idx].start));
					tgt = longint'(it.amount);
					prod = (tgt - st) * e;
					if (prod >= 0) v = st + (prod >>> 16);
					else v = st - ((-prod + 65535) >>> 16);
					if (v > 64'sd2147483647) v = 64'sd2147483647;
					if (v < -64'sd2147483648) v = -64'sd2147483648;
					tweens[idx].last = v[31:0];
					r.value = v[31:0];
					r.status = etw_pkg::ST_FOUND;
				end else begin
					r.value = it.amount;
					r.status = etw_pkg::ST_ABSENT;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		etw_pkg::out_item_t exp_item;
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected item %h", out_data);
			end else begin
				exp_item = expected_q.pop_front();
				if (out_data.value !== exp_item.value || out_data.status !== exp_item.status
					|| out_data.removed !== exp_item.removed) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
							exp_item.value, exp_item.status, exp_item.removed,
							out_data.value, out_data.status, out_data.removed);
				end
			end
		end
	end

	initial begin
		int w;
		forever begin
			w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic send_item(etw_pkg::in_item_t it);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(predict_table(it));
	endtask

	task automatic drain_and_write(logic [17:0] val);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		overshoot = val;
	endtask

	function automatic etw_pkg::in_item_t mk(logic [1:0] c, logic [63:0] k, logic [31:0] a,
		logic [31:0] d, logic [31:0] el, logic [1:0] ez);
		etw_pkg::in_item_t it;
		it.cmd = c; it.key = k; it.amount = a; it.duration = d;
		it.elapsed = el; it.ease = ez;
		return it;
	endfunction

	function automatic logic [63:0] pick_key();
		if (keys_used.size() > 0 && $urandom_range(0, 4) != 0)
			return keys_used[$urandom_range(0, keys_used.size() - 1)];
		return {$urandom(), $urandom()};
	endfunction

	function automatic etw_pkg::in_item_t rand_item();
		etw_pkg::in_item_t it;
		logic [63:0] k;
		int sel;
		sel = $urandom_range(0, 99);
		k = pick_key();
		it = mk(etw_pkg::CMD_GET, k, $urandom(), $urandom(), $urandom(),
			2'($urandom_range(0, 3)));
		if ($urandom_range(0, 2) == 0) it.duration = $urandom_range(1, 1 << 18);
		if ($urandom_range(0, 3) != 0) it.elapsed = $urandom_range(0, 1 << 16);
		if (sel < 35) begin
			it.cmd = etw_pkg::CMD_START;
			keys_used.push_back(k);
			if (keys_used.size() > 48) void'(keys_used.pop_front());
		end else if (sel < 75) it.cmd = etw_pkg::CMD_GET;
		else if (sel < 98) it.cmd = etw_pkg::CMD_TICK;
		else it.cmd = CMD_UNUSED;
		return it;
	endfunction

	task automatic test_directed();
		send_item(mk(etw_pkg::CMD_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1, 0,
			etw_pkg::EASE_LINEAR));
		send_item(mk(etw_pkg::CMD_START, 64'd0, 32'h8000_0000, 32'hFFFF_FFFF, 0,
			etw_pkg::EASE_LINEAR));
		send_item(mk(etw_pkg::CMD_START, 64'd1, 32'h7FFF_FFFF, 32'h0001_0000, 0,
			etw_pkg::EASE_BACK));
		send_item(mk(etw_pkg::CMD_START, 64'd2, 32'h0, 32'h0002_0000, 0,
			etw_pkg::EASE_CUBIC));
		send_item(mk(etw_pkg::CMD_START, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0, 0,
			etw_pkg::EASE_QUINT));
		send_item(mk(etw_pkg::CMD_TICK, 64'd0, 0, 0, 32'h0000_4000, etw_pkg::EASE_LINEAR));
		send_item(mk(etw_pkg::CMD_GET, 64'd1, 32'h7FFF_FFFF, 0, 0, etw_pkg::EASE_LINEAR));
		send_item(mk(etw_pkg::CMD_GET, 64'd0, 32'h7FFF_FFFF, 0, 0, etw_pkg::EASE_LINEAR));
		send_item(mk(etw_pkg::CMD_GET, 64'd2, 32'h8000_0000, 0, 0, etw_pkg::EASE_LINEAR));
		send_item(mk(etw_pkg::CMD_START, 64'd2, 32'h1234, 32'h0001_0000, 0,
			etw_pkg::EASE_QUINT));
		send_item(mk(CMD_UNUSED, 64'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			etw_pkg::EASE_QUINT));
		send_item(mk(etw_pkg::CMD_GET, 64'd2, 32'h100_0000, 0, 0, etw_pkg::EASE_LINEAR));
		send_item(mk(etw_pkg::CMD_TICK, 64'd0, 0, 0, 32'hFFFF_FFFF, etw_pkg::EASE_LINEAR));
		for (int i = 0; i < 33; i++)
			send_item(mk(etw_pkg::CMD_START, 64'h100 + i, i << 16, 32'h0001_0000, 0, i[1:0]));
		send_item(mk(etw_pkg::CMD_TICK, 64'd0, 0, 0, 32'h0, etw_pkg::EASE_LINEAR));
		send_item(mk(etw_pkg::CMD_TICK, 64'd0, 0, 0, 32'hFFFF_FFFF, etw_pkg::EASE_LINEAR));
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) send_item(rand_item());
	endtask

	initial begin
		arst_n <= 1'b0;
		overshoot = etw_pkg::BACK_OVERSHOOT_RST;
		live = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		drain_and_write(18'h3FFFF);
		test_random(300);
		drain_and_write(18'h0);
		test_random(250);
		drain_and_write(18'($urandom_range(0, 18'h3FFFF)));
		test_random(250);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+design
design/etw_pkg.sv
design/etw_div.sv
design/eased_tween_table_unit.sv
tb/tb_top.sv
